/* src/t2u_pkg.sv */
// ----------------------------------------------------------------------------
// t2u_pkg
// shared types and constants for the text to utf-8 transcoder
// ----------------------------------------------------------------------------
package t2u_pkg;

  // encoding modes
  localparam logic [1:0] MODE_UTF8    = 2'd0;
  localparam logic [1:0] MODE_LATIN1  = 2'd1;
  localparam logic [1:0] MODE_UTF16LE = 2'd2;
  localparam logic [1:0] MODE_UTF16BE = 2'd3;

  // byte order mark bytes
  localparam logic [7:0] BOM8_B0 = 8'hEF;
  localparam logic [7:0] BOM8_B1 = 8'hBB;
  localparam logic [7:0] BOM8_B2 = 8'hBF;
  localparam logic [15:0] BOM16  = 16'hFEFF;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_IGNORE = 1'b1;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one classified input word: up to three output bytes, first in slot 0
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } t2u_job_t;

endpackage

/* src/text_to_utf8_transcoder.sv */
// ----------------------------------------------------------------------------
// text_to_utf8_transcoder
// utf-8 / latin-1 / utf-16 byte stream to utf-8 byte stream
// ----------------------------------------------------------------------------
// path: an accepted input word is queued, then loaded into the output register
// throughput: one input word per cycle while each gives one byte and out_stall
//   is low; a word of more bytes (3 max) slows it: one output register
// reset: mode utf-8, bom stripping on, message state cleared, queue and
//   output register empty; a register write also clears message state
// ----------------------------------------------------------------------------
module text_to_utf8_transcoder (
  input  logic                      clk,
  input  logic                      rst_n,
  // input words
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_byte,
  input  logic                      in_last,
  // output words
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      out_has_byte,
  output logic                      out_last,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [t2u_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import t2u_pkg::*;

  // configuration registers
  logic [1:0] mode_r;
  logic       ignore_bom_r;
  logic       cfg_wr;

  // front to queue to back
  logic     push;
  t2u_job_t push_job;
  logic     q_full;
  logic     q_valid;
  t2u_job_t q_job;
  logic     pop;

  // register port: word address in paddr[2], writes complete in access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_UTF8;
      ignore_bom_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODE:   mode_r       <= pwdata[1:0];
        REG_IGNORE: ignore_bom_r <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE:   prdata = {30'd0, mode_r};
      REG_IGNORE: prdata = {31'd0, ignore_bom_r};
      default:    prdata = '0;
    endcase
  end

  // front: takes words, strips the bom and forms byte groups
  t2u_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .keep_bom (ignore_bom_r),
    .clear    (cfg_wr),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // queue lets the front keep taking words while the back stalls
  t2u_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // back: one byte per cycle into the output register, unless the output stalls
  t2u_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

endmodule

/* src/t2u_front.sv */
// ----------------------------------------------------------------------------
// t2u_front
// accepts input words, tracks message state and forms output byte groups
// ----------------------------------------------------------------------------
module t2u_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        mode,
  input  logic              keep_bom,
  input  logic              clear,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              push,
  output t2u_pkg::t2u_job_t push_job
);
  import t2u_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [7:0] held_r, held_nxt;
  logic [1:0] hcnt_r, hcnt_nxt;
  logic       accept;
  logic       strip;
  logic [15:0] unit;
  t2u_job_t   job;

  function automatic t2u_job_t unit_job(input logic [15:0] cu);
    t2u_job_t j;
    j = '0;
    if (cu < 16'h0080) begin
      j.bytes[0] = {1'b0, cu[6:0]};
      j.cnt      = 2'd1;
    end else if (cu < 16'h0800) begin
      j.bytes[0] = {3'b110, cu[10:6]};
      j.bytes[1] = {2'b10, cu[5:0]};
      j.cnt      = 2'd2;
    end else begin
      j.bytes[0] = {4'b1110, cu[15:12]};
      j.bytes[1] = {2'b10, cu[11:6]};
      j.bytes[2] = {2'b10, cu[5:0]};
      j.cnt      = 2'd3;
    end
    return j;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign strip    = !keep_bom;
  assign unit     = (mode == MODE_UTF16LE) ? {in_byte, held_r} : {held_r, in_byte};

  always_comb begin
    job      = '0;
    held_nxt = held_r;
    hcnt_nxt = hcnt_r;
    unique case (mode)
      MODE_UTF8: begin
        unique case (hcnt_r)
          2'd0: begin
            if (strip && pos_r == 2'd0 && in_byte == BOM8_B0 && !in_last) begin
              held_nxt = BOM8_B0;
              hcnt_nxt = 2'd1;
            end else begin
              job.bytes[0] = in_byte;
              job.cnt      = 2'd1;
            end
          end
          2'd1: begin
            if (in_byte == BOM8_B1 && !in_last) begin
              held_nxt = BOM8_B1;
              hcnt_nxt = 2'd2;
            end else begin
              job.bytes[0] = BOM8_B0;
              job.bytes[1] = in_byte;
              job.cnt      = 2'd2;
              hcnt_nxt     = 2'd0;
            end
          end
          default: begin
            if (in_byte != BOM8_B2) begin
              job.bytes[0] = BOM8_B0;
              job.bytes[1] = BOM8_B1;
              job.bytes[2] = in_byte;
              job.cnt      = 2'd3;
            end
            hcnt_nxt = 2'd0;
          end
        endcase
      end
      MODE_LATIN1: begin
        if (!in_byte[7]) begin
          job.bytes[0] = in_byte;
          job.cnt      = 2'd1;
        end else begin
          job.bytes[0] = {6'b110000, in_byte[7:6]};
          job.bytes[1] = {2'b10, in_byte[5:0]};
          job.cnt      = 2'd2;
        end
      end
      default: begin
        // utf-16, either byte order
        if (hcnt_r == 2'd0) begin
          held_nxt = in_byte;
          hcnt_nxt = 2'd1;
        end else begin
          if (!(strip && pos_r == 2'd1 && unit == BOM16)) begin
            job = unit_job(unit);
          end
          hcnt_nxt = 2'd0;
        end
      end
    endcase
    job.last = in_last;
    pos_nxt  = (pos_r == 2'd3) ? pos_r : pos_r + 2'd1;
    if (in_last) begin
      pos_nxt  = 2'd0;
      held_nxt = '0;
      hcnt_nxt = 2'd0;
    end
  end

  assign push     = accept && (job.cnt != 2'd0 || in_last);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      pos_r  <= 2'd0;
      held_r <= '0;
      hcnt_r <= 2'd0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  // latin-1 never holds a byte back
  a_latin_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mode == MODE_LATIN1 && hcnt_r == 2'd0 && !clear |=> hcnt_r == 2'd0 || $changed(mode))
    else $error("front holds a byte in latin-1 mode");

endmodule

/* src/t2u_queue.sv */
// ----------------------------------------------------------------------------
// t2u_queue
// short fifo of byte groups between front and back
// ----------------------------------------------------------------------------
module t2u_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  t2u_pkg::t2u_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              q_valid,
  output t2u_pkg::t2u_job_t q_job
);
  import t2u_pkg::*;

  t2u_job_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_job   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

/* src/t2u_back.sv */
// ----------------------------------------------------------------------------
// t2u_back
// walks each byte group and drives the registered output channel
// ----------------------------------------------------------------------------
module t2u_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  t2u_pkg::t2u_job_t q_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_has_byte,
  output logic              out_last
);
  import t2u_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       has_byte_r;
  logic       out_last_r;
  logic       ld;
  logic       job_done;
  logic [7:0] sel_byte;

  assign ld       = q_valid && (!out_valid_r || !out_stall);
  assign job_done = (q_job.cnt == 2'd0) || (idx_r == q_job.cnt - 2'd1);
  assign pop      = ld && job_done;

  always_comb begin
    unique case (idx_r)
      2'd0:    sel_byte = q_job.bytes[0];
      2'd1:    sel_byte = q_job.bytes[1];
      default: sel_byte = q_job.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld) begin
        out_valid_r <= 1'b1;
        idx_r       <= job_done ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_byte_r <= (q_job.cnt == 2'd0) ? 8'h00 : sel_byte;
      has_byte_r <= (q_job.cnt != 2'd0);
      out_last_r <= q_job.last && job_done;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_byte = has_byte_r;
  assign out_last     = out_last_r;

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !has_byte_r |-> out_last_r && out_byte_r == 8'h00)
    else $error("bare end marker without last");

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (idx_r < q_job.cnt) || (idx_r == 2'd0))
    else $error("byte index beyond group");

endmodule

/* tb/tb_text_to_utf8_transcoder.sv */
// ----------------------------------------------------------------------------
// tb_text_to_utf8_transcoder
// self-checking bench for the text to utf-8 transcoder: an in-bench model of
// the four input encodings and bom handling predicts every output word, and
// random idle and stall phases plus one long output hold exercise flow control
// ----------------------------------------------------------------------------
module tb_text_to_utf8_transcoder;
  timeunit 1ns;
  timeprecision 1ps;

  import t2u_pkg::*;

  localparam int DRAIN_CYCLES = 8;       // settle time after the last output word
  localparam int HOLD_CYCLES  = 150;     // long output hold to back up the input
  localparam int TIMEOUT_NS   = 1000000;

  // --------------------------------------------------------------------------
  // scoreboard: predicts utf-8 words per accepted input word, checks outputs
  // --------------------------------------------------------------------------
  class utf8_scoreboard;
    typedef struct {
      logic [7:0] data;
      logic       has_data;
      logic       last;
    } utf8_word_t;

    utf8_word_t  expected_q[$];
    logic [1:0]  mode;
    logic        keep_bom;
    logic [1:0]  position;   // bytes seen in this message, saturating
    logic [15:0] held;       // bom prefix or first byte of a utf-16 pair
    logic [1:0]  held_n;
    int          errors;
    int          checked;

    function new();
      mode     = MODE_UTF8;
      keep_bom = 1'b0;
      errors   = 0;
      checked  = 0;
      clear_message();
    endfunction

    function void clear_message();
      position = '0;
      held     = '0;
      held_n   = '0;
    endfunction

    // any register write restarts the message
    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_MODE) mode = value[1:0];
      else keep_bom = value[0];
      clear_message();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_word(logic [7:0] b, logic last);
      logic [7:0]  produced[$];
      logic [15:0] unit;
      bit          strip;
      utf8_word_t  w;
      strip = !keep_bom;
      case (mode)
        MODE_UTF8: begin
          if (held_n == 2'd0) begin
            if (strip && position == 2'd0 && b == BOM8_B0 && !last) begin
              held   = {8'h00, b};
              held_n = 2'd1;
            end else begin
              produced.push_back(b);
            end
          end else if (held_n == 2'd1) begin
            if (b == BOM8_B1 && !last) begin
              held   = {BOM8_B1, BOM8_B0};
              held_n = 2'd2;
            end else begin
              produced.push_back(BOM8_B0);
              produced.push_back(b);
              held   = '0;
              held_n = 2'd0;
            end
          end else begin
            // third byte completes the bom (dropped) or breaks it
            if (b != BOM8_B2) begin
              produced.push_back(BOM8_B0);
              produced.push_back(BOM8_B1);
              produced.push_back(b);
            end
            held   = '0;
            held_n = 2'd0;
          end
        end
        MODE_LATIN1: begin
          if (b < 8'h80) begin
            produced.push_back(b);
          end else begin
            produced.push_back({6'b110000, b[7:6]});
            produced.push_back({2'b10, b[5:0]});
          end
        end
        default: begin
          if (held_n == 2'd0) begin
            held   = {8'h00, b};
            held_n = 2'd1;
          end else begin
            unit = (mode == MODE_UTF16LE) ? {b, held[7:0]} : {held[7:0], b};
            if (!(strip && position == 2'd1 && unit == BOM16)) begin
              if (unit < 16'h0080) begin
                produced.push_back(unit[7:0]);
              end else if (unit < 16'h0800) begin
                produced.push_back({3'b110, unit[10:6]});
                produced.push_back({2'b10, unit[5:0]});
              end else begin
                produced.push_back({4'b1110, unit[15:12]});
                produced.push_back({2'b10, unit[11:6]});
                produced.push_back({2'b10, unit[5:0]});
              end
            end
            held   = '0;
            held_n = 2'd0;
          end
        end
      endcase

      if (position != 2'd3) position++;

      // a final byte with nothing to show still ends the message
      if (last && produced.size() == 0) begin
        w.data     = 8'h00;
        w.has_data = 1'b0;
        w.last     = 1'b1;
        expected_q.push_back(w);
      end
      foreach (produced[i]) begin
        w.data     = produced[i];
        w.has_data = 1'b1;
        w.last     = last && (i == produced.size() - 1);
        expected_q.push_back(w);
      end
      if (last) clear_message();
    endfunction

    function void check_word(logic [7:0] data, logic has_data, logic last);
      utf8_word_t w;
      if (expected_q.size() == 0) begin
        $error("unexpected output word: out_byte=%h out_has_byte=%b out_last=%b",
               data, has_data, last);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      checked++;
      if (data !== w.data) begin
        $error("out_byte: expected %h, actual %h", w.data, data);
        errors++;
      end
      if (has_data !== w.has_data) begin
        $error("out_has_byte: expected %b, actual %b", w.has_data, has_data);
        errors++;
      end
      if (last !== w.last) begin
        $error("out_last: expected %b, actual %b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte   = 8'h00;
  logic        in_last   = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_has_byte;
  logic        out_last;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  utf8_scoreboard sc = new();

  int         send_idle      = 0;   // percent of cycles the sender sits idle
  int         stall_pct      = 0;   // percent of cycles the receiver stalls
  bit         hold_start     = 1'b0;
  int         hold_left      = 0;
  int         words_sent     = 0;
  int         messages_sent  = 0;
  int         reg_writes     = 0;
  int         reg_errors     = 0;
  logic [1:0] cur_mode       = MODE_UTF8;

  text_to_utf8_transcoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS * 1ns);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: checks every accepted output word and drives out_stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sc.check_word(out_byte, out_has_byte, out_last);
    // long hold requested by the stimulus, counted down here
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // offer one word, with random idle cycles ahead of it, and wait for it to go
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sc.note_word(b, last);
    words_sent++;
    if (last) messages_sent++;
  endtask

  // apb write, then read the register back
  task automatic set_register(input logic idx, input logic [31:0] value);
    logic [31:0] field_mask;
    field_mask = (idx == REG_MODE) ? 32'h3 : 32'h1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sc.set_reg(idx, value);
    reg_writes++;
    // read phase keeps psel high and goes back through setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & field_mask) !== (value & field_mask)) begin
      $error("register %0d readback: expected %h, actual %h",
             idx, value & field_mask, prdata & field_mask);
      reg_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, wait until all predicted words are out, then settle for
  // DRAIN_CYCLES for words that give nothing
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sc.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic keep);
    wait_drained();
    set_register(REG_MODE, {30'd0, mode});
    set_register(REG_IGNORE, {31'd0, keep});
    cur_mode = mode;
  endtask

  // one message: optional bom or part of one, then text bytes biased so
  // that utf-16 units land in the one, two and three byte ranges
  task automatic send_random_message(input int min_len, input int max_len);
    logic [7:0] msg[$];
    logic [7:0] bom[3];
    int         len;
    int         bom_n;
    if (cur_mode == MODE_UTF16LE) begin
      bom   = '{8'hFF, 8'hFE, 8'h00};
      bom_n = 2;
    end else if (cur_mode == MODE_UTF16BE) begin
      bom   = '{8'hFE, 8'hFF, 8'h00};
      bom_n = 2;
    end else begin
      bom   = '{BOM8_B0, BOM8_B1, BOM8_B2};
      bom_n = 3;
    end
    case ($urandom_range(5))
      2, 3: for (int i = 0; i < bom_n; i++) msg.push_back(bom[i]);
      4: for (int i = 0; i < $urandom_range(1, bom_n - 1); i++) msg.push_back(bom[i]);
      5: begin
        // utf-8 bom in whatever mode is set
        msg.push_back(BOM8_B0);
        msg.push_back(BOM8_B1);
        msg.push_back(BOM8_B2);
      end
      default: ;
    endcase
    len = $urandom_range(min_len, max_len);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: msg.push_back(8'h00);
        1: msg.push_back(8'($urandom_range(7)));
        2: msg.push_back(8'($urandom_range(127)));
        default: msg.push_back(8'($urandom_range(255)));
      endcase
    end
    foreach (msg[i]) send_word(msg[i], i == msg.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         send_idle_tab[4];
    int         stall_tab[4];
    int         start;
    logic [1:0] mode;

    // idle phases: none, sender gaps, receiver stalls, both a little
    send_idle_tab = '{0, 61, 0, 12};
    stall_tab     = '{0, 0, 61, 12};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: utf-8 bom handling
    configure(MODE_UTF8, 1'b0);
    // bom alone leaves only an end marker
    send_word(8'hEF, 1'b0); send_word(8'hBB, 1'b0); send_word(8'hBF, 1'b1);
    // bom broken on its third byte
    send_word(8'hEF, 1'b0); send_word(8'hBB, 1'b0); send_word(8'h00, 1'b1);
    // message ends inside the bom prefix
    send_word(8'hEF, 1'b0); send_word(8'hBB, 1'b1);
    send_word(8'hEF, 1'b1);

    // directed: latin-1 extremes, one and two byte forms
    configure(MODE_LATIN1, 1'b0);
    send_word(8'h00, 1'b0); send_word(8'h7F, 1'b0);
    send_word(8'h80, 1'b0); send_word(8'hFF, 1'b1);

    // directed: utf-16le with bom, a three byte unit and an odd trailing byte
    configure(MODE_UTF16LE, 1'b0);
    send_word(8'hFF, 1'b0); send_word(8'hFE, 1'b0);
    send_word(8'h00, 1'b0); send_word(8'h08, 1'b0);
    send_word(8'h41, 1'b1);

    // directed: utf-16be with bom, unit 0xffff and the two byte top end
    configure(MODE_UTF16BE, 1'b0);
    send_word(8'hFE, 1'b0); send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0); send_word(8'hFF, 1'b0);
    send_word(8'h07, 1'b0); send_word(8'hFF, 1'b1);

    // directed: a register write mid-message drops the held bom byte
    configure(MODE_UTF8, 1'b0);
    send_word(8'hEF, 1'b0);
    wait_drained();
    set_register(REG_IGNORE, 32'd0);
    send_word(8'hBB, 1'b0); send_word(8'hBF, 1'b1);

    // random: every mode in every idle phase, bom keep or strip at random
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 4; k++) begin
        mode = 2'(k + p);
        configure(mode, 1'($urandom_range(1)));
        send_idle = send_idle_tab[p];
        stall_pct = stall_tab[p];
        if (p == 0 && k == 0) begin
          // long output hold while words keep coming: input must back up
          hold_start = 1'b1;
          send_random_message(16, 20);
        end
        start = words_sent;
        while (words_sent - start < 18) send_random_message(1, 8);
        // drain with no idling so config writes are not slowed down
        send_idle = 0;
      end
    end

    wait_drained();

    $display("covered %0d input words in %0d messages, %0d output words checked",
             words_sent, messages_sent, sc.checked);
    $display("all four encodings with bom kept and stripped, %0d register writes",
             reg_writes);
    if (sc.errors == 0 && reg_errors == 0 && sc.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
